FILE: src/lrpa_pkg.sv
// Shared types, constants and helpers for the line rasterizer pixel address block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lrpa_pkg;

    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int ADDR_W  = 17;
    localparam int MASK_W  = 8;
    localparam int ERR_W   = 11;
    localparam int DEPTH_W = 2;
    localparam int SCALE_W = 2;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_DEPTH = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 2'd3;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 2'd1;

    // 1bpp line length in bytes, per scale select
    localparam logic [6:0] LINE_BYTES [4] = '{7'd0, 7'd80, 7'd40, 7'd20};
    // leftmost pixel mask, per depth code
    localparam logic [MASK_W-1:0] FIRST_MASK [4] = '{8'h80, 8'hC0, 8'hF0, 8'hFF};

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [DEPTH_W-1:0] depth;
        logic [SCALE_W-1:0] scale;
    } lrpa_cfg_t;

    // classified command, as queued between front and stepper
    typedef struct packed {
        logic           kind;
        logic [X_W-1:0] cur_x;
        logic [Y_W-1:0] cur_y;
        logic [X_W-1:0] major_end;
        logic [X_W-1:0] major_delta;
        logic [X_W-1:0] minor_delta;
        logic           x_is_major;
        logic           minor_dec;
    } lrpa_cmd_t;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic           last;
    } lrpa_pix_t;

    function automatic logic [MASK_W-1:0] pixel_mask(
        input logic [DEPTH_W-1:0] depth,
        input logic [2:0]         x_low
    );
        logic [2:0] sh;
        sh = (x_low & (3'b111 >> depth)) << depth;
        return FIRST_MASK[depth] >> sh;
    endfunction

endpackage

`default_nettype wire

FILE: src/line_rasterizer_pixel_address.sv
// Bresenham line rasterizer with packed-bitmap pixel address and mask output.
// Item path: queue, stepper pixel register, mid and output registers; m_tready stalls hold it.
// Throughput: one item per cycle unless m_tready stalls, set by one stepper error update per cycle.
// An advance item with no line in progress gives no pixel.
// Reset (rst_n low, async): config to base 0, depth code 3, scale select 1; stepper idle,
// queue and pipeline empty. Depends on lrpa_pkg, lrpa_front, lrpa_queue, lrpa_stepper, lrpa_addr.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_pixel_address
    import lrpa_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // start_x[9:0], end_x[19:10], start_y[28:20], end_y[37:29]
    input  wire logic        s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // pixel_x[9:0], pixel_y[18:10], pixel_address[35:19],
                                        // pixel_mask[43:36]
    output logic             m_tlast    // last_point
);

    logic [ADDR_W-1:0]  base_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [SCALE_W-1:0] scale_reg;
    lrpa_cfg_t          cfg;

    logic       queue_full, push, pop, pop_valid, p_valid, p_ready;
    lrpa_cmd_t  push_entry, pop_entry;
    lrpa_pix_t  p_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_RESET;
            depth_reg <= DEPTH_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE:  base_reg  <= cfg_data;
                REG_DEPTH: depth_reg <= cfg_data[DEPTH_W-1:0];
                REG_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                default:   ;
            endcase
        end
    end

    assign cfg = '{base: base_reg, depth: depth_reg, scale: scale_reg};

    lrpa_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    lrpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    lrpa_stepper u_stepper (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_entry (pop_entry),
        .q_pop   (pop),
        .p_valid (p_valid),
        .p_pix   (p_pix),
        .p_ready (p_ready)
    );

    lrpa_addr u_addr (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .p_valid  (p_valid),
        .p_pix    (p_pix),
        .p_ready  (p_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: src/lrpa_front.sv
// Front end: takes input items, classifies start/advance and sets up the octant.
// Depends on lrpa_pkg; feeds lrpa_queue.
`timescale 1ns / 1ps
`default_nettype none

module lrpa_front
    import lrpa_pkg::*;
(
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [39:0]     s_tdata,
    input  wire logic            s_tuser,
    input  wire logic            queue_full,
    output logic                 push,
    output lrpa_cmd_t            push_entry
);

    logic [X_W-1:0] sx, ex, dx, dy;
    logic [Y_W-1:0] sy, ey, dy_n;
    logic           x_up, y_up, x_major;

    assign sx = s_tdata[9:0];
    assign ex = s_tdata[19:10];
    assign sy = s_tdata[28:20];
    assign ey = s_tdata[37:29];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb
    begin
        x_up    = sx < ex;
        y_up    = sy < ey;
        dx      = x_up ? ex - sx : sx - ex;
        dy_n    = y_up ? ey - sy : sy - ey;
        dy      = {1'b0, dy_n};
        x_major = dy < dx;

        push_entry            = '0;
        push_entry.kind       = s_tuser;
        push_entry.x_is_major = x_major;
        push_entry.minor_dec  = x_up != y_up;
        if (x_major)
        begin
            push_entry.cur_x       = x_up ? sx : ex;
            push_entry.cur_y       = x_up ? sy : ey;
            push_entry.major_end   = x_up ? ex : sx;
            push_entry.major_delta = dx;
            push_entry.minor_delta = dy;
        end
        else
        begin
            // ties in y start at the second endpoint
            push_entry.cur_x       = y_up ? sx : ex;
            push_entry.cur_y       = y_up ? sy : ey;
            push_entry.major_end   = {1'b0, (y_up ? ey : sy)};
            push_entry.major_delta = dy;
            push_entry.minor_delta = dx;
        end
    end

endmodule

`default_nettype wire

FILE: src/lrpa_queue.sv
// Command queue between front end and stepper.
// Depends on lrpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrpa_queue
    import lrpa_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire lrpa_cmd_t push_entry,
    output logic           full,
    input  wire logic      pop,
    output logic           pop_valid,
    output lrpa_cmd_t      pop_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lrpa_cmd_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = count_reg == CW'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

FILE: src/lrpa_stepper.sv
// Back end: Bresenham stepper, one error update per item, registered pixel out.
// Depends on lrpa_pkg; fed by lrpa_queue, feeds lrpa_addr.
`timescale 1ns / 1ps
`default_nettype none

module lrpa_stepper
    import lrpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_valid,
    input  wire lrpa_cmd_t q_entry,
    output logic           q_pop,
    output logic           p_valid,
    output lrpa_pix_t      p_pix,
    input  wire logic      p_ready
);

    logic             active_reg, active_next;
    logic [X_W-1:0]   cur_x_reg, cur_x_next;
    logic [Y_W-1:0]   cur_y_reg, cur_y_next;
    logic [X_W-1:0]   major_end_reg, major_end_next;
    logic [X_W-1:0]   major_delta_reg, major_delta_next;
    logic [X_W-1:0]   minor_delta_reg, minor_delta_next;
    logic [ERR_W-1:0] error_reg, error_next;
    logic             x_major_reg, x_major_next;
    logic             minor_dec_reg, minor_dec_next;
    logic             p_valid_reg, p_valid_next;
    lrpa_pix_t        pix_reg, pix_next;

    logic             p_free, emit, last;
    logic [ERR_W-1:0] err_sum;
    logic [X_W-1:0]   major_pos;

    assign p_valid = p_valid_reg;
    assign p_pix   = pix_reg;

    always_comb
    begin
        active_next      = active_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        major_end_next   = major_end_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        error_next       = error_reg;
        x_major_next     = x_major_reg;
        minor_dec_next   = minor_dec_reg;
        emit             = 1'b0;
        err_sum          = error_reg + {1'b0, minor_delta_reg};

        p_free = !p_valid_reg || p_ready;
        q_pop  = q_valid && p_free;

        if (q_pop)
        begin
            if (q_entry.kind == CMD_START)
            begin
                cur_x_next       = q_entry.cur_x;
                cur_y_next       = q_entry.cur_y;
                major_end_next   = q_entry.major_end;
                major_delta_next = q_entry.major_delta;
                minor_delta_next = q_entry.minor_delta;
                x_major_next     = q_entry.x_is_major;
                minor_dec_next   = q_entry.minor_dec;
                error_next       = {2'b00, q_entry.minor_delta[X_W-1:1]};
                emit             = 1'b1;
            end
            else if (active_reg)
            begin
                emit = 1'b1;
                if (x_major_reg)
                    cur_x_next = cur_x_reg + 1'b1;
                else
                    cur_y_next = cur_y_reg + 1'b1;
                error_next = err_sum;
                if ({1'b0, major_delta_reg} < err_sum)
                begin
                    error_next = err_sum - {1'b0, major_delta_reg};
                    if (x_major_reg)
                        cur_y_next = minor_dec_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                    else
                        cur_x_next = minor_dec_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                end
            end
        end

        major_pos = x_major_next ? cur_x_next : {1'b0, cur_y_next};
        last      = major_pos == major_end_next;
        if (emit)
            active_next = !last;

        p_valid_next = p_free ? emit : p_valid_reg;
        pix_next     = pix_reg;
        if (emit)
            pix_next = '{x: cur_x_next, y: cur_y_next, last: last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
        major_end_reg   <= major_end_next;
        major_delta_reg <= major_delta_next;
        minor_delta_reg <= minor_delta_next;
        error_reg       <= error_next;
        x_major_reg     <= x_major_next;
        minor_dec_reg   <= minor_dec_next;
        pix_reg         <= pix_next;
    end

endmodule

`default_nettype wire

FILE: src/lrpa_addr.sv
// Pixel address and mask pipeline: row product stage, then final sum into output register.
// Depends on lrpa_pkg; fed by lrpa_stepper, drives the master stream.
`timescale 1ns / 1ps
`default_nettype none

module lrpa_addr
    import lrpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire lrpa_cfg_t cfg,
    input  wire logic      p_valid,
    input  wire lrpa_pix_t p_pix,
    output logic           p_ready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output logic [47:0]    m_tdata,
    output logic           m_tlast
);

    logic              mid_valid_reg;
    lrpa_pix_t         mid_pix_reg;
    logic [ADDR_W-1:0] mid_row_reg, mid_row_next;
    logic [X_W-1:0]    mid_xoff_reg, mid_xoff_next;
    logic [MASK_W-1:0] mid_mask_reg, mid_mask_next;

    logic              out_valid_reg;
    lrpa_pix_t         out_pix_reg;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [MASK_W-1:0] out_mask_reg;

    logic              mid_free, out_free;
    logic [X_W-1:0]    stride;
    logic [18:0]       row_prod;

    assign out_free = !out_valid_reg || m_tready;
    assign mid_free = !mid_valid_reg || out_free;
    assign p_ready  = mid_free;

    always_comb
    begin
        stride        = X_W'({3'b000, LINE_BYTES[cfg.scale]} << cfg.depth);
        row_prod      = 19'(p_pix.y) * 19'(stride);
        mid_row_next  = row_prod[ADDR_W-1:0];
        mid_xoff_next = p_pix.x >> (~cfg.depth);
        mid_mask_next = pixel_mask(cfg.depth, p_pix.x[2:0]);
        out_addr_next = cfg.base + mid_row_reg + {{(ADDR_W - X_W){1'b0}}, mid_xoff_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mid_free)
                mid_valid_reg <= p_valid;
            if (out_free)
                out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_free && p_valid)
        begin
            mid_pix_reg  <= p_pix;
            mid_row_reg  <= mid_row_next;
            mid_xoff_reg <= mid_xoff_next;
            mid_mask_reg <= mid_mask_next;
        end
        if (out_free && mid_valid_reg)
        begin
            out_pix_reg  <= mid_pix_reg;
            out_addr_reg <= out_addr_next;
            out_mask_reg <= mid_mask_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_pix_reg.last;
    assign m_tdata  = {4'b0000, out_mask_reg, out_addr_reg, out_pix_reg.y, out_pix_reg.x};

endmodule

`default_nettype wire
